// File: rtl/core/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

    // Default sizing of the code
    localparam int MAX_SHARDS_DEF = 255;
    localparam int MAX_PARITY_DEF = 64;

    // Field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [8:0] FIELD_POLY = 9'h11D;

    // Configuration register indexes
    localparam logic REG_DATA_COUNT   = 1'b0;
    localparam logic REG_PARITY_COUNT = 1'b1;

    typedef logic [7:0] t_byte_tbl [256];

    // Control broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic       upd;       // accumulate this request
        logic       first;     // shard 0: overwrite instead of add
        logic       load;      // column complete: copy sums into drain chain
        logic       shift;     // one parity byte taken: drain chain moves
        logic [7:0] key_base;  // low byte of P + shard index
        logic [7:0] data;      // data byte
    } t_cell_ctrl;

    // GF(2^8) multiply, shift-and-add
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) r = r ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ FIELD_POLY;
        end
        return r;
    endfunction

    // Inverse table built from powers of the generator 2; zero maps to zero
    function automatic t_byte_tbl gf_inv_table();
        t_byte_tbl  tbl;
        t_byte_tbl  pw;
        logic [8:0] x;
        int         e;
        tbl = '{default: 8'h00};
        pw  = '{default: 8'h00};
        x   = 9'd1;
        for (int k = 0; k < 255; k++) begin
            pw[k] = x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ FIELD_POLY;
        end
        for (int k = 0; k < 255; k++) begin
            e = (k == 0) ? 0 : 255 - k;
            tbl[pw[k]] = pw[e];
        end
        return tbl;
    endfunction

    localparam t_byte_tbl GF_INV = gf_inv_table();

endpackage

// File: rtl/core/crs_channels.sv
`timescale 1ns / 1ps

// Data request channel: one byte of one data shard
interface crs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] shard_index;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output shard_index, output data_byte,
                    output block_end, input ready);
    modport sink   (input valid, input shard_index, input data_byte,
                    input block_end, output ready);
endinterface

// Parity request channel: one byte of one parity shard
interface crs_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] parity_index;
    logic [7:0] parity_byte;
    logic       column_last;
    logic       block_end_out;
    logic       bad_config;

    modport source (output valid, output parity_index, output parity_byte,
                    output column_last, output block_end_out, output bad_config,
                    input ready);
    modport sink   (input valid, input parity_index, input parity_byte,
                    input column_last, input block_end_out, input bad_config,
                    output ready);
endinterface

// File: rtl/core/crs_cell.sv
`timescale 1ns / 1ps

// One parity shard: accumulator plus one stage of the drain chain
module crs_cell #(
    parameter int J = 0
) (
    input  logic                i_clk,
    input  crs_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]          i_shift_in,
    output logic [7:0]          o_shift_out
);

    logic [7:0] r_acc;
    logic [7:0] n_acc;
    logic [7:0] r_shift;
    logic [7:0] w_key;
    logic [7:0] w_coef;
    logic [7:0] w_prod;

    // Cauchy coefficient inv((P + i) xor j) times the data byte
    assign w_key  = i_ctrl.key_base ^ 8'(J);
    assign w_coef = crs_pkg::GF_INV[w_key];
    assign w_prod = crs_pkg::gf_mul(w_coef, i_ctrl.data);

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.upd) begin
            n_acc = i_ctrl.first ? w_prod : (r_acc ^ w_prod);
        end
    end

    // Accumulator and drain stage; load takes priority over the shift
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctrl.load) begin
            r_shift <= n_acc;
        end else if (i_ctrl.shift) begin
            r_shift <= i_shift_in;
        end
    end

    assign o_shift_out = r_shift;

endmodule

// File: rtl/core/cauchy_rs_erasure_encoder.sv
`timescale 1ns / 1ps

// Cauchy Reed-Solomon parity generator over GF(2^8) (poly 0x11D). Data bytes
// come in column order, shards 0..D-1 for one byte position, one request per
// cycle while the input is not stalled. A row of MAX_PARITY cells updates all
// parity sums in the cycle a byte is taken. The byte of shard D-1 loads the
// sums into a shift chain through the cells, which drains one parity byte per
// cycle at cell 0 while the output is ready. The input stalls while the drain
// chain holds more than one parity byte, or one that the output is not ready
// to take; the next request is taken in the cycle the last parity byte leaves.
// With an unusable configuration every request gives one flagged result.
// Shard indexes of D or more are dropped silently. No clearing pass is run
// after reset; configure D and P only while no column is in flight.
module cauchy_rs_erasure_encoder #(
    parameter int MAX_SHARDS = crs_pkg::MAX_SHARDS_DEF,
    parameter int MAX_PARITY = crs_pkg::MAX_PARITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    crs_in_if.sink     i_req,
    crs_out_if.source  o_par
);

    logic [7:0] r_data_count;
    logic [6:0] r_parity_count;
    logic       r_end_flag;
    logic       n_end_flag;
    logic [6:0] r_cnt;
    logic [6:0] n_cnt;
    logic [5:0] r_idx;
    logic       r_out_end;
    logic       r_out_bad;

    logic       w_bad;
    logic       w_accept;
    logic       w_upd;
    logic       w_emit;
    logic       w_first;
    logic       w_pop;
    logic [8:0] w_sum;
    crs_pkg::t_cell_ctrl w_ctrl;
    logic [7:0] w_chain [MAX_PARITY+1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_count   <= 8'd1;
            r_parity_count <= 7'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crs_pkg::REG_DATA_COUNT:   r_data_count   <= i_cfg_data;
                crs_pkg::REG_PARITY_COUNT: r_parity_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Configuration check
    assign w_sum = {1'b0, r_data_count} + {2'b00, r_parity_count};
    assign w_bad = (r_data_count == 8'd0) || (r_parity_count == 7'd0)
                || (r_parity_count > 7'(MAX_PARITY)) || (w_sum > 9'(MAX_SHARDS));

    // Handshakes
    assign w_pop       = o_par.valid && o_par.ready;
    assign i_req.ready = (r_cnt == 7'd0) || ((r_cnt == 7'd1) && o_par.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_upd       = w_accept && !w_bad && (i_req.shard_index < r_data_count);
    assign w_first     = (i_req.shard_index == 8'd0);
    assign w_emit      = w_upd && (i_req.shard_index == (r_data_count - 8'd1));

    // Column end flag
    always_comb begin
        n_end_flag = r_end_flag;
        if (w_upd) begin
            n_end_flag = w_first ? i_req.block_end : (r_end_flag | i_req.block_end);
        end
    end

    // Results left in the drain chain
    always_comb begin
        n_cnt = r_cnt;
        if (w_accept && w_bad) begin
            n_cnt = 7'd1;
        end else if (w_emit) begin
            n_cnt = r_parity_count;
        end else if (w_pop) begin
            n_cnt = r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_flag <= 1'b0;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_out_end  <= 1'b0;
            r_out_bad  <= 1'b0;
        end else begin
            r_end_flag <= n_end_flag;
            r_cnt      <= n_cnt;
            if (w_accept && w_bad) begin
                r_idx     <= '0;
                r_out_end <= i_req.block_end;
                r_out_bad <= 1'b1;
            end else if (w_emit) begin
                r_idx     <= '0;
                r_out_end <= n_end_flag;
                r_out_bad <= 1'b0;
            end else if (w_pop) begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    // Broadcast to the cells
    always_comb begin
        w_ctrl.upd      = w_upd;
        w_ctrl.first    = w_first;
        w_ctrl.load     = w_emit;
        w_ctrl.shift    = w_pop;
        w_ctrl.key_base = i_req.shard_index + {1'b0, r_parity_count};
        w_ctrl.data     = i_req.data_byte;
    end

    // Row of parity cells; the drain chain runs toward cell 0
    assign w_chain[MAX_PARITY] = 8'h00;
    for (genvar g = 0; g < MAX_PARITY; g++) begin : g_cell
        crs_cell #(
            .J (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_shift_in  (w_chain[g+1]),
            .o_shift_out (w_chain[g])
        );
    end

    // Result outputs
    assign o_par.valid         = (r_cnt != 7'd0);
    assign o_par.parity_index  = r_idx;
    assign o_par.parity_byte   = r_out_bad ? 8'h00 : w_chain[0];
    assign o_par.column_last   = (r_cnt == 7'd1);
    assign o_par.block_end_out = r_out_end;
    assign o_par.bad_config    = r_out_bad;

    // A new request is only taken once the drain chain is empty or emptying
    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_cnt <= 7'd1))
        else $error("request taken while parity bytes still queued");

    // A finished column queues exactly P results, starting at parity shard 0
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_cnt == $past(r_parity_count)) && (r_idx == 6'd0))
        else $error("column did not queue P parity bytes");

    // Parity index advances by one on each mid-column hand-off
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (r_cnt > 7'd1)) |=> (r_idx == $past(r_idx) + 6'd1))
        else $error("parity index skipped");

    // A bad-configuration result is always alone and last
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_par.valid && r_out_bad) |-> (r_cnt == 7'd1))
        else $error("flagged result not single");

    // With nothing queued the input side is open
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_par.valid |-> i_req.ready)
        else $error("input stalled with empty drain chain");

endmodule

// File: tb/cauchy_rs_erasure_encoder_test.sv
`timescale 1ns / 1ps

module cauchy_rs_erasure_encoder_test;

    // One parity request as seen on the output channel
    typedef struct packed {
        logic [5:0] pidx;
        logic [7:0] pbyte;
        logic       last;
        logic       bend_out;
        logic       bad;
    } t_parity_rec;

    // Parity predictor and scoreboard: own GF(2^8) math, accumulators and code setting
    class t_parity_board;
        t_parity_rec parity_due[$];
        logic [7:0]  inv_of [256];
        logic [7:0]  acc [crs_pkg::MAX_PARITY_DEF];
        logic        end_seen;
        int          data_count;
        int          parity_count;
        int          errors;
        int          results_seen;

        function new();
            for (int a = 0; a < 256; a++) begin
                inv_of[a] = 8'h00;
                for (int b = 1; b < 256; b++) begin
                    if (field_mul(a[7:0], b[7:0]) == 8'h01) inv_of[a] = b[7:0];
                end
            end
            foreach (acc[j]) acc[j] = 8'h00;
            end_seen     = 1'b0;
            data_count   = 1;
            parity_count = 1;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Carry-less multiply, reduced by x^8+x^4+x^3+x^2+1 each step
        function logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
            logic [7:0] r;
            logic [7:0] x;
            r = 8'h00;
            x = a;
            for (int k = 0; k < 8; k++) begin
                if (b[k]) r = r ^ x;
                x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
            end
            return r;
        endfunction

        function bit code_bad();
            return data_count == 0 || parity_count == 0
                || parity_count > crs_pkg::MAX_PARITY_DEF
                || data_count + parity_count > crs_pkg::MAX_SHARDS_DEF;
        endfunction

        // Request the block drops without any result
        function bit dropped(int shard);
            return !code_bad() && shard >= data_count;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == crs_pkg::REG_DATA_COUNT) begin
                data_count = int'(value);
            end else begin
                parity_count = int'(value[6:0]);
            end
        endfunction

        // Accepted data request: update sums, queue parity when the column completes
        function void take_byte(logic [7:0] shard, logic [7:0] data, logic bend);
            t_parity_rec rec;
            logic [7:0]  key;
            logic [7:0]  prod;
            if (code_bad()) begin
                rec.pidx     = 6'd0;
                rec.pbyte    = 8'h00;
                rec.last     = 1'b1;
                rec.bend_out = bend;
                rec.bad      = 1'b1;
                parity_due.push_back(rec);
                return;
            end
            if (shard >= data_count) return;
            end_seen = (shard == 0) ? bend : (end_seen | bend);
            for (int j = 0; j < parity_count; j++) begin
                key  = 8'(parity_count + shard);
                key  = key ^ j[7:0];
                prod = field_mul(inv_of[key], data);
                acc[j] = (shard == 0) ? prod : (acc[j] ^ prod);
            end
            if (shard != data_count - 1) return;
            for (int j = 0; j < parity_count; j++) begin
                rec.pidx     = j[5:0];
                rec.pbyte    = acc[j];
                rec.last     = (j == parity_count - 1);
                rec.bend_out = end_seen;
                rec.bad      = 1'b0;
                parity_due.push_back(rec);
            end
        endfunction

        function void check_parity(t_parity_rec got);
            t_parity_rec want;
            results_seen++;
            if (parity_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected parity: idx=%0d byte=%h last=%b end=%b bad=%b",
                             got.pidx, got.pbyte, got.last, got.bend_out, got.bad);
                errors++;
                return;
            end
            want = parity_due.pop_front();
            if (want !== got) begin
                if (errors < 10)
                    $display({"parity mismatch: want idx=%0d byte=%h last=%b end=%b bad=%b,",
                              " got idx=%0d byte=%h last=%b end=%b bad=%b"},
                             want.pidx, want.pbyte, want.last, want.bend_out, want.bad,
                             got.pidx, got.pbyte, got.last, got.bend_out, got.bad);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    crs_in_if  req ();
    crs_out_if par ();

    t_parity_board board;

    logic [15:0] rx_pattern;
    logic [3:0]  rx_step = 4'd0;
    int          gap_max = 0;
    int          burst_left = 0;
    bit          column_open = 1'b0;
    int          items_counted = 0;
    int          settings_used = 1;

    cauchy_rs_erasure_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req),
        .o_par       (par)
    );

    always #2 i_clk = ~i_clk;

    // Receiver stalls follow a rotating 16-bit pattern
    always @(posedge i_clk) begin
        par.ready <= rx_pattern[rx_step];
        rx_step   <= rx_step + 4'd1;
    end

    // Both handshakes sampled at the edge; input noted before output is checked
    always @(posedge i_clk) begin
        t_parity_rec got;
        if (i_rst_n) begin
            if (req.valid && req.ready)
                board.take_byte(req.shard_index, req.data_byte, req.block_end);
            if (par.valid && par.ready) begin
                got.pidx     = par.parity_index;
                got.pbyte    = par.parity_byte;
                got.last     = par.column_last;
                got.bend_out = par.block_end_out;
                got.bad      = par.bad_config;
                board.check_parity(got);
            end
        end
    end

    // Sender pacing and receiver pattern for the next stretch
    task automatic set_pace(input bit calm);
        gap_max = calm ? 0 : $urandom_range(2, 8);
        rx_pattern <= calm ? 16'hFFFF : (16'($urandom) | 16'h1111);
    endtask

    // Drive one data request, bursts with random gaps; returns at the accepting edge
    task automatic push_byte(input int shard, input logic [7:0] data, input logic bend);
        int gap;
        // never add into sums that were not started under the current setting
        if (!board.code_bad() && shard < board.data_count) begin
            if (shard != 0 && !column_open) shard = 0;
            if (shard == 0) column_open = 1'b1;
        end
        if (!board.dropped(shard)) items_counted++;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req.valid       <= 1'b1;
        req.shard_index <= shard[7:0];
        req.data_byte   <= data;
        req.block_end   <= bend;
        do @(posedge i_clk); while (req.ready !== 1'b1);
    endtask

    // Drain, settle, then write D and P on back-to-back cycles
    task automatic set_code(input int d, input int p);
        req.valid <= 1'b0;
        burst_left = 0;
        // first let the last accepted request reach the board
        @(posedge i_clk);
        while (board.parity_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= crs_pkg::REG_DATA_COUNT;
        i_cfg_data  <= d[7:0];
        @(posedge i_clk);
        board.write_reg(crs_pkg::REG_DATA_COUNT, d[7:0]);
        i_cfg_index <= crs_pkg::REG_PARITY_COUNT;
        i_cfg_data  <= p[7:0];
        @(posedge i_clk);
        board.write_reg(crs_pkg::REG_PARITY_COUNT, p[7:0]);
        i_cfg_we <= 1'b0;
        column_open = 1'b0;
        settings_used++;
    endtask

    // Shards 0..stop_at with random bytes, optionally skipping middle shards
    task automatic send_column(input int stop_at, input bit skip_some);
        for (int s = 0; s <= stop_at; s++) begin
            if (!(skip_some && s != 0 && s != stop_at && $urandom_range(0, 1)))
                push_byte(s, 8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end
    endtask

    // Mostly full columns; some skipped shards, cut-off columns and stray indexes
    task automatic random_traffic(input int target);
        int start;
        int d;
        int pick;
        start = items_counted;
        while (items_counted - start < target) begin
            d    = board.data_count;
            pick = $urandom_range(0, 9);
            if (board.code_bad() || pick == 9) begin
                repeat ($urandom_range(1, 3))
                    push_byte($urandom_range(0, 254), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end else if (pick == 8 && d > 1) begin
                send_column($urandom_range(0, d - 2), 1'b0);
            end else begin
                send_column(d - 1, pick == 7);
            end
        end
    endtask

    initial begin
        board = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= crs_pkg::REG_DATA_COUNT;
        i_cfg_data      <= 8'h00;
        req.valid       <= 1'b0;
        req.shard_index <= 8'h00;
        req.data_byte   <= 8'h00;
        req.block_end   <= 1'b0;
        rx_pattern      <= 16'hFFFF;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: single data shard, single parity; stray shard indexes
        set_pace(1'b1);
        push_byte(0, 8'h00, 1'b0);
        push_byte(0, 8'hFF, 1'b1);
        push_byte(1, 8'h5A, 1'b0);
        push_byte(254, 8'hC3, 1'b1);

        // Block end ORed over the column, and a column with a skipped shard
        set_code(3, 2);
        push_byte(0, 8'hFF, 1'b0);
        push_byte(1, 8'h80, 1'b1);
        push_byte(2, 8'h01, 1'b0);
        push_byte(0, 8'h12, 1'b1);
        push_byte(2, 8'h34, 1'b0);

        // Size extremes
        set_pace(1'b0);
        set_code(1, 64);
        push_byte(0, 8'hA5, 1'b0);
        set_code(191, 64);
        push_byte(0, 8'hFF, 1'b1);
        push_byte(190, 8'hFF, 1'b0);
        set_code(254, 1);
        push_byte(0, 8'h7E, 1'b0);
        push_byte(253, 8'h81, 1'b1);
        push_byte(254, 8'h00, 1'b0);

        // Unusable settings: every request flagged
        set_code(0, 5);
        push_byte(0, 8'h3C, 1'b1);
        set_code(4, 0);
        push_byte(3, 8'h0F, 1'b0);
        set_code(4, 65);
        push_byte(200, 8'hF0, 1'b0);
        set_code(200, 56);
        push_byte(0, 8'h55, 1'b1);
        set_code(254, 127);
        push_byte(254, 8'hAA, 1'b1);

        // Random settings and traffic
        for (int k = 0; k < 5; k++) begin
            set_code((k == 4) ? $urandom_range(8, 24) : $urandom_range(1, 6),
                     $urandom_range(1, 6));
            set_pace(k == 3);
            random_traffic(40);
        end
        set_code($urandom_range(1, 3), $urandom_range(32, 64));
        set_pace(1'b0);
        random_traffic(15);
        set_code(254, $urandom_range(2, 64));
        random_traffic(12);

        req.valid <= 1'b0;
        @(posedge i_clk);
        while (board.parity_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d data requests under %0d code settings",
                 items_counted, settings_used);
        $display("checked %0d parity results, %0d mismatches",
                 board.results_seen, board.errors);
        if (board.errors == 0 && board.parity_due.size() == 0) begin
            $display("cauchy_rs_erasure_encoder_test: PASS");
        end else begin
            $display("cauchy_rs_erasure_encoder_test: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("cauchy_rs_erasure_encoder_test: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/crs_pkg.sv
rtl/core/crs_channels.sv
rtl/core/crs_cell.sv
rtl/core/cauchy_rs_erasure_encoder.sv
tb/cauchy_rs_erasure_encoder_test.sv
